// File: hw/rtl/fmas_pkg.sv
// Package for the flight mode assist sequencer.
// Holds state, result and settings types, state codes and the chain lookup.
// No dependencies.
package fmas_pkg;

    localparam logic [2:0] REG_MODE_TABLE   = 3'd0;
    localparam logic [2:0] REG_ASSIST_TABLE = 3'd1;
    localparam logic [2:0] REG_STAB_TABLE   = 3'd2;
    localparam logic [2:0] REG_THR_NEUTRAL  = 3'd3;
    localparam logic [2:0] REG_NEUTRAL_OFS  = 3'd4;
    localparam logic [2:0] REG_THR_MIN      = 3'd5;

    localparam int STAB_MODES  = 6;
    localparam int STAB_TBL_W  = 3 * STAB_MODES;

    localparam logic [4:0] MODE_MANUAL    = 5'd0;
    localparam logic [4:0] MODE_STAB_LAST = 5'd6;
    localparam logic [4:0] MODE_POSHOLD   = 5'd7;
    localparam logic [4:0] MODE_PATH_LAST = 5'd15;
    localparam logic [4:0] MODE_PLANNER   = 5'd16;

    localparam logic [1:0] ASSIST_NONE        = 2'd0;
    localparam logic [1:0] ASSIST_GPS         = 2'd1;
    localparam logic [1:0] ASSIST_GPS_PRIMARY = 2'd2;

    localparam logic [1:0] CTL_PRIMARY = 2'd0;
    localparam logic [1:0] CTL_BRAKE   = 2'd1;
    localparam logic [1:0] CTL_HOLD    = 2'd2;

    localparam logic [1:0] THR_MANUAL   = 2'd0;
    localparam logic [1:0] THR_AUTO     = 2'd1;
    localparam logic [1:0] THR_OVERRIDE = 2'd2;

    localparam logic [1:0] HND_MANUAL   = 2'd0;
    localparam logic [1:0] HND_STAB     = 2'd1;
    localparam logic [1:0] HND_FOLLOWER = 2'd2;
    localparam logic [1:0] HND_PLANNER  = 2'd3;

    localparam logic [2:0] TM_CRUISE   = 3'd1;
    localparam logic [2:0] TM_ALTHOLD  = 3'd2;
    localparam logic [2:0] TM_ALTVARIO = 3'd3;

    typedef struct packed {
        logic [14:0]        neutral;
        logic signed [15:0] offset;
        logic [14:0]        min;
    } fmas_thr_cfg_t;

    typedef struct packed {
        logic [4:0]         mode;
        logic [1:0]         assist;
        logic [1:0]         ctl;
        logic [1:0]         thr;
        logic               first;
        logic signed [15:0] brake_thr;
    } fmas_state_t;

    typedef struct packed {
        logic [4:0] mode;
        logic [1:0] assist;
        logic [1:0] ctl;
        logic [1:0] thr;
        logic [1:0] handler;
        logic [2:0] chain;
        logic       changed;
    } fmas_res_t;

    function automatic logic [2:0] chain_of(input logic [1:0] handler);
        logic [2:0] c;
        unique case (handler)
            HND_MANUAL:   c = 3'b000;
            HND_STAB:     c = 3'b001;
            HND_FOLLOWER: c = 3'b011;
            HND_PLANNER:  c = 3'b111;
            default:      c = 3'b000;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/flight_mode_assist_sequencer_unit.sv
// Top level of the flight mode assist sequencer: input register, state,
// result register and the settings port. Depends on fmas_pkg, fmas_cfg, fmas_eval.
//
// One control tick per word. A word is taken into the input register, evaluated
// combinationally against the stored mode and control state and lands in the result
// register, and a new word may be accepted every cycle while out_ready does not stall
// the output; the state update rides on the same edge that loads the result register.
// Settings are written through the cfg channel (always ready) and should only change
// while no word is in flight.
module flight_mode_assist_sequencer_unit #(
    parameter int POSITIONS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [((5*POSITIONS > 18) ? 5*POSITIONS : 18)-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           switch_position,
    input  logic signed [15:0]   roll_cmd,
    input  logic signed [15:0]   pitch_cmd,
    input  logic signed [15:0]   thrust_cmd,
    input  logic                 hold_reached,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           flight_mode,
    output logic [1:0]           mode_assist,
    output logic [1:0]           control_state,
    output logic [1:0]           throttle_state,
    output logic [1:0]           handler_select,
    output logic [2:0]           control_chain,
    output logic                 status_changed
);
    import fmas_pkg::*;

    localparam int CFG_W = (5*POSITIONS > 18) ? 5*POSITIONS : 18;

    logic [5*POSITIONS-1:0] mode_table;
    logic [2*POSITIONS-1:0] assist_table;
    logic [STAB_TBL_W-1:0]  stab_table;
    fmas_thr_cfg_t          thr_cfg;

    logic               in_vld_reg;
    logic               in_vld_next;
    logic [2:0]         pos_reg;
    logic signed [15:0] roll_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] thrust_reg;
    logic               hold_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    fmas_res_t          res_reg;
    fmas_res_t          res_next;
    fmas_state_t        state_reg;
    fmas_state_t        state_next;
    logic               advance;
    logic               take;

    assign cfg_ready = 1'b1;

    fmas_cfg #(
        .POSITIONS (POSITIONS),
        .CFG_W     (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (cfg_valid),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .mode_table   (mode_table),
        .assist_table (assist_table),
        .stab_table   (stab_table),
        .thr_cfg      (thr_cfg)
    );

    fmas_eval #(
        .POSITIONS (POSITIONS)
    ) u_eval (
        .pos          (pos_reg),
        .roll         (roll_reg),
        .pitch        (pitch_reg),
        .thrust       (thrust_reg),
        .hold         (hold_reg),
        .mode_table   (mode_table),
        .assist_table (assist_table),
        .stab_table   (stab_table),
        .thr_cfg      (thr_cfg),
        .cur          (state_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            state_reg.mode      <= MODE_MANUAL;
            state_reg.assist    <= ASSIST_NONE;
            state_reg.ctl       <= CTL_PRIMARY;
            state_reg.thr       <= THR_MANUAL;
            state_reg.first     <= 1'b1;
            state_reg.brake_thr <= 16'sd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_reg    <= switch_position;
            roll_reg   <= roll_cmd;
            pitch_reg  <= pitch_cmd;
            thrust_reg <= thrust_cmd;
            hold_reg   <= hold_reached;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid      = out_vld_reg;
    assign flight_mode    = res_reg.mode;
    assign mode_assist    = res_reg.assist;
    assign control_state  = res_reg.ctl;
    assign throttle_state = res_reg.thr;
    assign handler_select = res_reg.handler;
    assign control_chain  = res_reg.chain;
    assign status_changed = res_reg.changed;

endmodule

// File: hw/rtl/fmas_cfg.sv
// Settings registers of the flight mode assist sequencer.
// Depends on fmas_pkg.
module fmas_cfg #(
    parameter int POSITIONS = 6,
    parameter int CFG_W     = 30
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [2:0]             wr_index,
    input  logic [CFG_W-1:0]       wr_data,
    output logic [5*POSITIONS-1:0] mode_table,
    output logic [2*POSITIONS-1:0] assist_table,
    output logic [fmas_pkg::STAB_TBL_W-1:0] stab_table,
    output fmas_pkg::fmas_thr_cfg_t thr_cfg
);
    import fmas_pkg::*;

    logic [5*POSITIONS-1:0] mode_table_reg;
    logic [2*POSITIONS-1:0] assist_table_reg;
    logic [STAB_TBL_W-1:0]  stab_table_reg;
    fmas_thr_cfg_t          thr_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_table_reg     <= '0;
            assist_table_reg   <= '0;
            stab_table_reg     <= '0;
            thr_cfg_reg.neutral <= 15'd16384;
            thr_cfg_reg.offset  <= 16'sd0;
            thr_cfg_reg.min     <= 15'd6554;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE_TABLE:   mode_table_reg      <= wr_data[5*POSITIONS-1:0];
                REG_ASSIST_TABLE: assist_table_reg    <= wr_data[2*POSITIONS-1:0];
                REG_STAB_TABLE:   stab_table_reg      <= wr_data[STAB_TBL_W-1:0];
                REG_THR_NEUTRAL:  thr_cfg_reg.neutral <= wr_data[14:0];
                REG_NEUTRAL_OFS:  thr_cfg_reg.offset  <= signed'(wr_data[15:0]);
                REG_THR_MIN:      thr_cfg_reg.min     <= wr_data[14:0];
                default:          ;
            endcase
        end
    end

    assign mode_table   = mode_table_reg;
    assign assist_table = assist_table_reg;
    assign stab_table   = stab_table_reg;
    assign thr_cfg      = thr_cfg_reg;

endmodule

// File: hw/rtl/fmas_eval.sv
// Per-tick decision logic: mode lookup, assist choice and the
// primary/brake/hold machine. Purely combinational. Depends on fmas_pkg.
module fmas_eval #(
    parameter int POSITIONS = 6
) (
    input  logic [2:0]               pos,
    input  logic signed [15:0]       roll,
    input  logic signed [15:0]       pitch,
    input  logic signed [15:0]       thrust,
    input  logic                     hold,
    input  logic [5*POSITIONS-1:0]   mode_table,
    input  logic [2*POSITIONS-1:0]   assist_table,
    input  logic [fmas_pkg::STAB_TBL_W-1:0] stab_table,
    input  fmas_pkg::fmas_thr_cfg_t  thr_cfg,
    input  fmas_pkg::fmas_state_t    cur,
    output fmas_pkg::fmas_state_t    nxt,
    output fmas_pkg::fmas_res_t      res
);
    import fmas_pkg::*;

    logic               pos_ok;
    logic [4:0]         mode_sel;
    logic [1:0]         opt_sel;
    logic [2:0]         tm;
    logic [1:0]         assist_cfg;
    logic [1:0]         cur_ctl;
    logic [4:0]         mode;
    logic [1:0]         assist;
    logic [1:0]         ctl;
    logic [1:0]         thr;
    logic [1:0]         handler;
    logic [1:0]         pf;
    logic               stick;
    logic               brake_start;
    logic signed [17:0] s_sum;
    logic signed [20:0] t21;
    logic signed [20:0] s21;
    logic signed [20:0] t5;
    logic signed [20:0] s4;
    logic signed [20:0] s6;
    logic               neutral;
    logic               neutral_or_low;
    logic signed [23:0] t24;
    logic signed [23:0] b24;
    logic signed [23:0] t100;
    logic signed [23:0] b92;
    logic signed [23:0] b108;
    logic               out_of_band;
    logic               below_min;

    always_comb
    begin
        mode_sel = cur.mode;
        opt_sel  = ASSIST_NONE;
        for (int p = 0; p < POSITIONS; p++)
        begin
            if (pos == 3'(p))
            begin
                mode_sel = mode_table[5*p +: 5];
                opt_sel  = assist_table[2*p +: 2];
            end
        end
        tm = TM_CRUISE;
        for (int m = 0; m < STAB_MODES; m++)
        begin
            if (mode == 5'(m + 1))
                tm = stab_table[3*m +: 3];
        end
        if (mode == MODE_POSHOLD)
            tm = TM_ALTVARIO;
    end

    assign pos_ok = {1'b0, pos} < 4'(POSITIONS);
    assign mode   = pos_ok ? mode_sel : cur.mode;

    always_comb
    begin
        if (!pos_ok || opt_sel != ASSIST_GPS)
            assist_cfg = ASSIST_NONE;
        else if (tm == TM_ALTHOLD || tm == TM_ALTVARIO)
            assist_cfg = ASSIST_GPS_PRIMARY;
        else
            assist_cfg = ASSIST_GPS;
    end

    // neutral band: 4S < 5T < 6S
    assign s_sum = signed'({3'b000, thr_cfg.neutral}) + 18'(thr_cfg.offset);
    assign t21   = 21'(thrust);
    assign s21   = 21'(s_sum);
    assign t5    = (t21 <<< 2) + t21;
    assign s4    = s21 <<< 2;
    assign s6    = (s21 <<< 2) + (s21 <<< 1);
    assign neutral_or_low = t5 < s6;
    assign neutral        = (t5 > s4) && neutral_or_low;

    // deadband around the brake-start thrust, 0.92 and 1.08 with a quarter-unit margin
    assign t24  = 24'(thrust);
    assign b24  = 24'(cur.brake_thr);
    assign t100 = (t24 <<< 6) + (t24 <<< 5) + (t24 <<< 2);
    assign b92  = (b24 <<< 6) + (b24 <<< 4) + (b24 <<< 3) + (b24 <<< 2);
    assign b108 = (b24 <<< 6) + (b24 <<< 5) + (b24 <<< 3) + (b24 <<< 2);
    assign out_of_band = (t100 + 24'sd25 <= b92) || (t100 > b108 + 24'sd25);
    assign below_min   = 17'(thrust) < signed'({2'b00, thr_cfg.min});

    assign stick   = (roll != 16'sd0) || (pitch != 16'sd0);
    assign cur_ctl = (hold && cur.ctl == CTL_BRAKE) ? CTL_HOLD : cur.ctl;

    always_comb
    begin
        assist      = cur.assist;
        ctl         = cur_ctl;
        thr         = cur.thr;
        handler     = HND_MANUAL;
        brake_start = 1'b0;
        pf          = (assist_cfg == ASSIST_GPS) ? THR_AUTO : THR_MANUAL;
        if (mode != cur.mode)
        begin
            assist = ASSIST_NONE;
            ctl    = CTL_PRIMARY;
            thr    = THR_MANUAL;
        end
        priority if (mode == MODE_MANUAL)
        begin
            handler = HND_MANUAL;
        end
        else if (mode <= MODE_STAB_LAST)
        begin
            handler = HND_STAB;
            assist  = assist_cfg;
            if (assist_cfg != ASSIST_NONE)
            begin
                priority case (ctl)
                    CTL_PRIMARY:
                    begin
                        if (!stick)
                        begin
                            ctl         = CTL_BRAKE;
                            thr         = below_min ? THR_MANUAL : pf;
                            handler     = HND_FOLLOWER;
                            brake_start = 1'b1;
                        end
                        else
                            thr = THR_MANUAL;
                    end
                    CTL_BRAKE:
                    begin
                        if (stick)
                        begin
                            ctl = CTL_PRIMARY;
                            thr = THR_MANUAL;
                        end
                        else
                        begin
                            thr     = (pf == THR_AUTO && out_of_band) ? THR_MANUAL : pf;
                            handler = HND_FOLLOWER;
                        end
                    end
                    CTL_HOLD:
                    begin
                        if (assist_cfg == ASSIST_GPS_PRIMARY || thr == THR_MANUAL)
                        begin
                            if (stick)
                                ctl = CTL_PRIMARY;
                            else
                                handler = HND_FOLLOWER;
                            thr = THR_MANUAL;
                        end
                        else if (neutral_or_low && stick)
                        begin
                            ctl = CTL_PRIMARY;
                            thr = THR_MANUAL;
                        end
                        else
                        begin
                            if (thr == THR_AUTO)
                                thr = neutral ? THR_OVERRIDE : THR_AUTO;
                            else if (thr == THR_OVERRIDE)
                                thr = neutral ? THR_OVERRIDE : THR_MANUAL;
                            else
                                thr = pf;
                            handler = HND_FOLLOWER;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else if (mode == MODE_POSHOLD)
        begin
            assist = assist_cfg;
            if (assist_cfg != ASSIST_NONE)
            begin
                thr = pf;
                if (ctl == CTL_PRIMARY)
                    ctl = CTL_BRAKE;
            end
            handler = HND_FOLLOWER;
        end
        else if (mode <= MODE_PATH_LAST)
        begin
            handler = HND_FOLLOWER;
        end
        else if (mode == MODE_PLANNER)
        begin
            handler = HND_PLANNER;
        end
        else
        begin
            handler = HND_MANUAL;
        end
    end

    always_comb
    begin
        res.mode    = mode;
        res.assist  = assist;
        res.ctl     = ctl;
        res.thr     = thr;
        res.handler = handler;
        res.chain   = chain_of(handler);
        res.changed = cur.first || mode != cur.mode || assist != cur.assist
                      || ctl != cur_ctl || thr != cur.thr;
        nxt.mode      = mode;
        nxt.assist    = assist;
        nxt.ctl       = ctl;
        nxt.thr       = thr;
        nxt.first     = 1'b0;
        nxt.brake_thr = brake_start ? thrust : cur.brake_thr;
    end

endmodule
